>>> design/assert_macros.svh
// Assertion macros shared by the pulse wind speed averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, sampled on clk_i, off during reset.
`define PWSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent, sampled on clk_i, off during reset.
`define PWSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pwsa_pkg.sv
// Types, widths and constants of the pulse wind speed averager.
package pwsa_pkg;

  // Field widths
  localparam int unsigned SampleW   = 12;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned SppW      = 16;
  localparam int unsigned WindowW   = 24;
  localparam int unsigned PulseW    = 16;
  localparam int unsigned SpeedW    = PulseW + SppW;
  localparam int unsigned AvgW      = 32;
  localparam int unsigned SumW      = 56;
  localparam int unsigned CountW    = 24;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Serial unit step counters
  localparam int unsigned MulCntW = $clog2(SppW);
  localparam int unsigned DivCntW = $clog2(SumW);

  // Register reset values
  localparam logic [SampleW-1:0]   ThresholdRst = SampleW'(2048);
  localparam logic [IntervalW-1:0] IntervalRst  = IntervalW'(1000);
  localparam logic [SppW-1:0]      SppRst       = SppW'(256);
  localparam logic [WindowW-1:0]   WindowRst    = WindowW'(600000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_INTERVAL_MS    = 2'd1,
    CFG_SPEED_PER_PULSE = 2'd2,
    CFG_AVERAGE_WINDOW = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               ms_tick;
  } in_item_t;

  typedef struct packed {
    logic              interval_done;
    logic [SpeedW-1:0] wind_speed;
    logic [AvgW-1:0]   average_speed;
    logic [PulseW-1:0] pulse_count;
  } out_item_t;

endpackage

>>> design/pwsa_mul.sv
// Bit-serial shift-add multiplier: pulses times speed factor.
module pwsa_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pwsa_pkg::PulseW-1:0]   mcand_i,
  input  logic [pwsa_pkg::SppW-1:0]     mplier_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [pwsa_pkg::SpeedW-1:0]   prod_o
);
  import pwsa_pkg::*;

  logic [SpeedW-1:0]  prod_q, prod_d;
  logic [PulseW-1:0]  mcand_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [PulseW:0]    upper_sum;

  // One multiplier bit per cycle: add into the upper half, shift right
  assign upper_sum = {1'b0, prod_q[SpeedW-1:SppW]}
                   + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign prod_d    = {upper_sum, prod_q[SppW-1:1]};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntW'(SppW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q  <= {{PulseW{1'b0}}, mplier_i};
      mcand_q <= mcand_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

>>> design/pwsa_div.sv
// Bit-serial restoring divider: speed sum over interval count.
module pwsa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pwsa_pkg::SumW-1:0]   dividend_i,
  input  logic [pwsa_pkg::CountW-1:0] divisor_i,
  output logic                        done_o,
  output logic [pwsa_pkg::SumW-1:0]   quotient_o
);
  import pwsa_pkg::*;

  logic [CountW-1:0]  rem_q;
  logic [SumW-1:0]    quo_q;
  logic [CountW-1:0]  den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [CountW:0]    trial;
  logic [CountW:0]    diff;
  logic               fits;

  // One quotient bit per cycle: bring down the next dividend bit and try
  assign trial = {rem_q, quo_q[SumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(SumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[CountW-1:0] : trial[CountW-1:0];
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/pulse_wind_speed_averager_unit.sv
// Top level of the pulse wind speed averager: counters, control and output register.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one ADC sample plus a
//   millisecond flag per item. Output channel (out_valid_o/out_ready_i/out_data_o)
//   gives exactly one result item per input item, in order.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i). The user
//   must write it only while the block is idle; the block itself does not enforce
//   this. Writes take effect at once.
// Item flow:
//   An item that does not close an interval passes the bit-serial multiplier (one
//   bit of the speed factor per cycle), then the push state loads its result into
//   the output register. An item that closes an interval also passes the bit-serial
//   divider for the average (one quotient bit per cycle) before the push state.
//   One item is in work at a time; the next is accepted the cycle after the
//   previous result is loaded into the output register.
// Reset: all counters, the running sum and the average clear; the registers take
//   their default values. No clearing pass is needed.
// Stall: a waiting result holds in the output register; while the receiver stalls,
//   one further item can be accepted and worked on, then the block waits.
module pulse_wind_speed_averager_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pwsa_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pwsa_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pwsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwsa_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pwsa_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  logic [SampleW-1:0]   thr_q;
  logic [IntervalW-1:0] interval_q;
  logic [SppW-1:0]      spp_q;
  logic [WindowW-1:0]   window_q;

  // Measurement state
  logic [SampleW-1:0]   prev_q;
  logic [PulseW-1:0]    pulses_q;
  logic [IntervalW-1:0] ms_int_q;
  logic [WindowW-1:0]   ms_win_q;
  logic [SumW-1:0]      sum_q;
  logic [CountW-1:0]    count_q;
  logic [AvgW-1:0]      avg_q;

  // Item in work
  logic                 closed_q;
  logic                 clear_q;
  logic [PulseW-1:0]    pc_q;
  logic [AvgW-1:0]      res_avg_q;

  // Output register
  out_item_t            out_q;
  logic                 out_valid_q, out_valid_d;

  state_e               state_q, state_d;

  logic                 accept;
  logic                 rise;
  logic [PulseW-1:0]    pulses_new;
  logic [IntervalW-1:0] ms_int_new;
  logic [WindowW-1:0]   ms_win_new;
  logic                 closed_now;
  logic                 clear_now;

  logic                 mul_busy, mul_done;
  logic [SpeedW-1:0]    mul_prod;
  logic                 mul_fin, div_start, div_done, load_out;
  logic [SumW-1:0]      div_quo;
  logic [SumW:0]        sum_ext;
  logic [SumW-1:0]      sum_new;
  logic [CountW-1:0]    count_new;
  logic [AvgW-1:0]      quo_sat;

  // Edge detection and millisecond counters for the incoming item
  assign rise       = (in_data_i.sample > thr_q) && (prev_q <= thr_q);
  assign pulses_new = pulses_q + PulseW'(rise && (pulses_q != '1));
  assign ms_int_new = ms_int_q + IntervalW'(in_data_i.ms_tick && (ms_int_q != '1));
  assign ms_win_new = ms_win_q + WindowW'(in_data_i.ms_tick && (ms_win_q != '1));
  // A zero interval acts as one millisecond
  assign closed_now = (ms_int_new >= interval_q) && (ms_int_new != '0);
  assign clear_now  = closed_now && (ms_win_new >= window_q);

  // Running sum and count after adding the closed interval, saturating
  assign sum_ext   = {1'b0, sum_q} + (SumW + 1)'(mul_prod);
  assign sum_new   = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
  assign count_new = count_q + CountW'(count_q != '1);
  assign quo_sat   = (|div_quo[SumW-1:AvgW]) ? '1 : div_quo[AvgW-1:0];

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    mul_fin     = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          mul_fin = 1'b1;
          if (closed_q) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  assign accept = in_valid_i && in_ready_o;

  // Configuration and measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThresholdRst;
      interval_q <= IntervalRst;
      spp_q      <= SppRst;
      window_q   <= WindowRst;
      prev_q     <= '0;
      pulses_q   <= '0;
      ms_int_q   <= '0;
      ms_win_q   <= '0;
      sum_q      <= '0;
      count_q    <= '0;
      avg_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_EDGE_THRESHOLD:  thr_q      <= cfg_wdata_i[SampleW-1:0];
          CFG_INTERVAL_MS:     interval_q <= cfg_wdata_i[IntervalW-1:0];
          CFG_SPEED_PER_PULSE: spp_q      <= cfg_wdata_i[SppW-1:0];
          CFG_AVERAGE_WINDOW:  window_q   <= cfg_wdata_i[WindowW-1:0];
        endcase
      end
      if (accept) begin
        prev_q   <= in_data_i.sample;
        pulses_q <= closed_now ? '0 : pulses_new;
        ms_int_q <= closed_now ? '0 : ms_int_new;
        ms_win_q <= clear_now ? '0 : ms_win_new;
      end
      // Interval close: fold in the speed, clear after the report if the window ran out
      if (mul_fin && closed_q) begin
        sum_q   <= clear_q ? '0 : sum_new;
        count_q <= clear_q ? '0 : count_new;
      end
      if (div_done) begin
        avg_q <= clear_q ? '0 : quo_sat;
      end
    end
  end

  // Per-item registers and output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      closed_q <= closed_now;
      clear_q  <= clear_now;
      pc_q     <= pulses_new;
    end
    if (mul_fin && !closed_q) begin
      res_avg_q <= avg_q;
    end
    if (div_done) begin
      res_avg_q <= quo_sat;
    end
    if (load_out) begin
      out_q.interval_done <= closed_q;
      out_q.wind_speed    <= mul_prod;
      out_q.average_speed <= res_avg_q;
      out_q.pulse_count   <= pc_q;
    end
  end

  pwsa_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .mcand_i  (pulses_new),
    .mplier_i (spp_q),
    .busy_o   (mul_busy),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  pwsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (count_new),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `PWSA_ASSERT_IMP(a_mul_start_free, accept, !mul_busy, "multiplier restarted while busy")
  `PWSA_ASSERT_NXT(a_one_item, accept, !in_ready_o, "second item taken while one in work")
  `PWSA_ASSERT_IMP(a_empty_sum, count_q == '0, sum_q == '0, "sum left with zero count")
  `PWSA_ASSERT_IMP(a_empty_avg, (state_q == S_IDLE) && (count_q == '0), avg_q == '0,
                   "average left with zero count")

endmodule

>>> sim/tb.sv
// Self-checking testbench of the pulse wind speed averager: directed table, then random phases.
module tb;
  import pwsa_pkg::*;

  // Run control
  localparam int unsigned HoldAt      = 200;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandPhases  = 10;

  // One row of the directed table: a register write or an item
  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] value;
    in_item_t            item;
    bit                  typed;
    out_item_t           want;
  } stim_row_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Shadow registers and counters of the speed predictor
  logic [SampleW-1:0]   thresh_r   = ThresholdRst;
  logic [IntervalW-1:0] interval_r = IntervalRst;
  logic [SppW-1:0]      spp_r      = SppRst;
  logic [WindowW-1:0]   window_r   = WindowRst;
  logic [SampleW-1:0]   last_sample = '0;
  logic [PulseW-1:0]    pulse_cnt   = '0;
  logic [IntervalW-1:0] ms_interval = '0;
  logic [WindowW-1:0]   ms_window   = '0;
  logic [SumW-1:0]      speed_sum   = '0;
  logic [CountW-1:0]    n_intervals = '0;

  out_item_t          pending_reports[$];
  stim_row_t          stim_table[$];
  logic [SampleW-1:0] last_offered = '0;
  int unsigned        send_run = 0;
  int unsigned        recv_run = 0;
  int unsigned        items_sent = 0;
  int unsigned        directed_items = 0;
  int unsigned        reg_writes = 0;
  int unsigned        reports_seen = 0;
  int unsigned        intervals_seen = 0;
  int unsigned        windows_cleared = 0;
  int unsigned        fail_count = 0;
  int unsigned        quiet_cycles = 0;

  pulse_wind_speed_averager_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // Advance the predictor by one sample and return the report it causes
  function automatic out_item_t anemometer_step(input in_item_t it);
    out_item_t            res;
    logic [IntervalW-1:0] lim;
    logic [SpeedW-1:0]    spd;
    logic [SumW:0]        acc;
    logic [SumW-1:0]      quo;
    logic                 closing;
    lim = (interval_r == '0) ? IntervalW'(1) : interval_r;
    // rising crossing of the threshold
    if (it.sample > thresh_r && last_sample <= thresh_r && pulse_cnt != '1) begin
      pulse_cnt++;
    end
    last_sample = it.sample;
    if (it.ms_tick) begin
      if (ms_interval != '1) ms_interval++;
      if (ms_window != '1) ms_window++;
    end
    spd = SpeedW'(pulse_cnt) * SpeedW'(spp_r);
    closing = (ms_interval >= lim);
    if (closing) begin
      acc = {1'b0, speed_sum} + (SumW+1)'(spd);
      speed_sum = acc[SumW] ? '1 : acc[SumW-1:0];
      if (n_intervals != '1) n_intervals++;
    end
    res.interval_done = closing;
    res.wind_speed    = spd;
    res.pulse_count   = pulse_cnt;
    if (n_intervals == '0) begin
      res.average_speed = '0;
    end else begin
      quo = speed_sum / SumW'(n_intervals);
      res.average_speed = (quo > SumW'(32'hFFFF_FFFF)) ? '1 : quo[AvgW-1:0];
    end
    // clears happen after the report
    if (closing) begin
      if (ms_window >= window_r) begin
        speed_sum   = '0;
        n_intervals = '0;
        ms_window   = '0;
        windows_cleared++;
      end
      pulse_cnt   = '0;
      ms_interval = '0;
    end
    return res;
  endfunction

  // Idle draw: usually a random gap, with occasional runs of back-to-back items
  function automatic int unsigned draw_wait(inout int unsigned run_left);
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Mostly clean threshold crossings, some samples at the threshold, some noise
  function automatic logic [SampleW-1:0] pick_sample(input logic [SampleW-1:0] thr,
                                                     input logic [SampleW-1:0] prev);
    case ($urandom_range(0, 9))
      6: return thr;
      7: return (thr == '1) ? thr : thr + 1'b1;
      8, 9: return SampleW'($urandom_range(0, 4095));
      default: begin
        if (prev > thr || thr == '1) return SampleW'($urandom_range(0, thr));
        return SampleW'($urandom_range(thr + 1, 4095));
      end
    endcase
  endfunction

  function automatic void add_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r = '{reg_idx: CFG_EDGE_THRESHOLD, default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = val;
    stim_table.push_back(r);
  endfunction

  function automatic void add_item(input logic [SampleW-1:0] s, input logic t);
    stim_row_t r;
    r = '{reg_idx: CFG_EDGE_THRESHOLD, default: '0};
    r.item.sample  = s;
    r.item.ms_tick = t;
    stim_table.push_back(r);
  endfunction

  function automatic void add_check(input logic [SampleW-1:0] s, input logic t,
                                    input logic done, input logic [SpeedW-1:0] spd,
                                    input logic [AvgW-1:0] avg, input logic [PulseW-1:0] pc);
    stim_row_t r;
    r = '{reg_idx: CFG_EDGE_THRESHOLD, default: '0};
    r.item.sample  = s;
    r.item.ms_tick = t;
    r.typed        = 1'b1;
    r.want.interval_done = done;
    r.want.wind_speed    = spd;
    r.want.average_speed = avg;
    r.want.pulse_count   = pc;
    stim_table.push_back(r);
  endfunction

  // Drive one item; valid stays high after acceptance until the next call decides
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t   pred;
    int unsigned gap;
    gap = draw_wait(send_run);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    pred = anemometer_step(it);
    pending_reports.push_back(typed ? want : pred);
    last_offered = it.sample;
    items_sent++;
  endtask

  // Stop offering and wait until every report has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EDGE_THRESHOLD:  thresh_r   = val[SampleW-1:0];
      CFG_INTERVAL_MS:     interval_r = val[IntervalW-1:0];
      CFG_SPEED_PER_PULSE: spp_r      = val[SppW-1:0];
      CFG_AVERAGE_WINDOW:  window_r   = val[WindowW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  // Compare one report with the oldest pending expectation
  task automatic check_report(input out_item_t got);
    out_item_t want;
    reports_seen++;
    if (got.interval_done) intervals_seen++;
    if (pending_reports.size() == 0) begin
      fail_count++;
      $display("%0t: report with no item pending, expected none, got %p", $time, got);
      return;
    end
    want = pending_reports.pop_front();
    if (got.interval_done !== want.interval_done) begin
      report_mismatch("interval_done", 32'(want.interval_done), 32'(got.interval_done));
    end
    if (got.wind_speed !== want.wind_speed) begin
      report_mismatch("wind_speed", want.wind_speed, got.wind_speed);
    end
    if (got.average_speed !== want.average_speed) begin
      report_mismatch("average_speed", want.average_speed, got.average_speed);
    end
    if (got.pulse_count !== want.pulse_count) begin
      report_mismatch("pulse_count", 32'(want.pulse_count), 32'(got.pulse_count));
    end
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up
  initial begin : drain_reports
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_wait(recv_run);
      if (!held && reports_seen >= HoldAt) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      check_report(out_data);
    end
  end

  // Watchdog on cycles where no item moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : drive_samples
    in_item_t    it;
    out_item_t   none;
    int unsigned n_items;
    logic [CfgDataW-1:0] val;
    none = '0;

    // Directed table; defaults first, so reset values are visible
    add_check(12'd0,    1'b0, 1'b0, 32'd0,   32'd0,   16'd0);
    add_check(12'd4095, 1'b1, 1'b0, 32'd256, 32'd0,   16'd1);
    add_check(12'd2048, 1'b0, 1'b0, 32'd256, 32'd0,   16'd1);
    add_check(12'd2049, 1'b1, 1'b0, 32'd512, 32'd0,   16'd2);
    // zero interval behaves as one millisecond
    add_reg(CFG_INTERVAL_MS, 24'd0);
    add_check(12'd0,    1'b1, 1'b1, 32'd512, 32'd512, 16'd2);
    // zero threshold, largest factor
    add_reg(CFG_SPEED_PER_PULSE, 24'd65535);
    add_reg(CFG_EDGE_THRESHOLD, 24'd0);
    add_check(12'd1,    1'b0, 1'b0, 32'd65535, 32'd512, 16'd1);
    add_item(12'd0,    1'b1);
    // zero window clears at every interval end
    add_reg(CFG_AVERAGE_WINDOW, 24'd0);
    add_item(12'd4095, 1'b1);
    add_item(12'd0,    1'b1);
    // top threshold can never be exceeded; zero factor
    add_reg(CFG_EDGE_THRESHOLD, 24'd4095);
    add_reg(CFG_SPEED_PER_PULSE, 24'd0);
    add_check(12'd4095, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0);
    add_check(12'd4095, 1'b1, 1'b1, 32'd0, 32'd0, 16'd0);
    // longest interval and window, then lower the interval under the elapsed count
    add_reg(CFG_INTERVAL_MS, 24'd65535);
    add_reg(CFG_AVERAGE_WINDOW, 24'hFF_FFFF);
    add_reg(CFG_EDGE_THRESHOLD, 24'd2048);
    add_reg(CFG_SPEED_PER_PULSE, 24'd256);
    add_item(12'd0,    1'b1);
    add_item(12'd3000, 1'b1);
    add_item(12'hAAA,  1'b1);
    add_item(12'h555,  1'b1);
    add_item(12'hAAA,  1'b0);
    add_reg(CFG_INTERVAL_MS, 24'd1);
    add_item(12'd100,  1'b0);
    add_reg(CFG_INTERVAL_MS, 24'd3);
    add_reg(CFG_AVERAGE_WINDOW, 24'd5);
    add_item(12'd4095, 1'b1);
    add_item(12'd0,    1'b1);
    add_item(12'd4095, 1'b1);
    add_item(12'd0,    1'b1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        wait_drained();
        write_reg(stim_table[i].reg_idx, stim_table[i].value);
      end else begin
        offer_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      end
    end
    directed_items = items_sent;

    // Random phases, each under a fresh register setting
    for (int p = 0; p < RandPhases; p++) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0: val = 24'd0;
        1: val = 24'd4095;
        default: val = CfgDataW'($urandom_range(0, 4095));
      endcase
      write_reg(CFG_EDGE_THRESHOLD, val);
      case ($urandom_range(0, 9))
        0: val = 24'd0;
        1: val = 24'd65535;
        2: val = CfgDataW'($urandom_range(7, 65535));
        default: val = CfgDataW'($urandom_range(1, 6));
      endcase
      write_reg(CFG_INTERVAL_MS, val);
      case ($urandom_range(0, 7))
        0: val = 24'd0;
        1: val = 24'd65535;
        default: val = CfgDataW'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_SPEED_PER_PULSE, val);
      case ($urandom_range(0, 7))
        0: val = 24'd0;
        1: val = 24'hFF_FFFF;
        default: val = CfgDataW'($urandom_range(1, 20));
      endcase
      write_reg(CFG_AVERAGE_WINDOW, val);
      n_items = $urandom_range(40, 64);
      for (int k = 0; k < n_items; k++) begin
        it.sample  = pick_sample(thresh_r, last_offered);
        it.ms_tick = ($urandom_range(0, 3) != 0);
        offer_item(it, 1'b0, none);
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d items (%0d from the table) across %0d register writes",
             items_sent, directed_items, reg_writes);
    $display("%0d intervals closed, %0d averaging windows cleared, one long receiver stall",
             intervals_seen, windows_cleared);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
